FILE: src/lag_load_aware_hash_select_core_assert.svh
// Assertion macros for the load-aware link aggregation selector.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef LAG_LOAD_AWARE_HASH_SELECT_CORE_ASSERT_SVH
`define LAG_LOAD_AWARE_HASH_SELECT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LAG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LAG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lag_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the load-aware link aggregation selector.
// Used by the modulo unit, the load table and the top level.
package lag_pkg;

	localparam int MAX_LINKS = 8;
	localparam int LOAD_BITS = 16;
	localparam int IDX_W = $clog2(MAX_LINKS);
	localparam int CNT_W = $clog2(MAX_LINKS + 1);

	localparam int HASH_W = 48;
	localparam int DIGIT_W = 4;
	localparam int MOD_STEPS = HASH_W / DIGIT_W;
	localparam int STEP_W = $clog2(MOD_STEPS);

	localparam int LINK_INDEX_W = 3;
	localparam int LINK_LOAD_W = 16;
	localparam int IN_DATA_W = 216;
	localparam int OUT_DATA_W = 24;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int LINK_COUNT_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_LINK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_LIMIT = CFG_IDX_W'(1);

	localparam logic [LINK_COUNT_W-1:0] LINK_COUNT_RESET = LINK_COUNT_W'(3);
	localparam logic [LINK_LOAD_W-1:0] LOAD_LIMIT_RESET = LINK_LOAD_W'(5);
	localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_SCAN,
		ST_UPDATE
	} lag_state_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} lag_mod_stat_t;

endpackage

FILE: src/lag_mod_unit.sv
`timescale 1ns / 1ps
// Iterative modulo unit: reduces the 48-bit hash by the link count, four bits per cycle.
// Depends on lag_pkg for widths and the status struct.
module lag_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lag_pkg::HASH_W-1:0]    dividend,
	input  logic [lag_pkg::CNT_W-1:0]     divisor,
	output lag_pkg::lag_mod_stat_t        stat
);

	logic [lag_pkg::HASH_W-1:0] div_q;
	logic [lag_pkg::CNT_W-1:0]  n_q;
	logic [lag_pkg::CNT_W-1:0]  rem_q;
	logic [lag_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [lag_pkg::CNT_W-1:0]  rem_next;

	always_comb begin
		logic [lag_pkg::CNT_W:0]   tmp;
		logic [lag_pkg::CNT_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < lag_pkg::DIGIT_W; k++) begin
			tmp = {r, div_q[lag_pkg::HASH_W-1-k]};
			if (tmp >= {1'b0, n_q}) begin
				tmp = tmp - {1'b0, n_q};
			end
			r = tmp[lag_pkg::CNT_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + lag_pkg::STEP_W'(1);
				if (cnt_q == lag_pkg::STEP_W'(lag_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			n_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[lag_pkg::HASH_W-lag_pkg::DIGIT_W-1:0], {lag_pkg::DIGIT_W{1'b0}}};
			rem_q <= rem_next;
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

FILE: src/lag_load_table.sv
`timescale 1ns / 1ps
// Per-link load counters with one read address and a saturating increment at that address.
// Depends on lag_pkg for the link count and load width.
module lag_load_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lag_pkg::IDX_W-1:0]     addr,
	input  logic                          inc_en,
	output logic [lag_pkg::LOAD_BITS-1:0] rd_load,
	output logic [lag_pkg::LOAD_BITS-1:0] new_load
);

	logic [lag_pkg::LOAD_BITS-1:0] loads_q [lag_pkg::MAX_LINKS];

	assign rd_load  = loads_q[addr];
	assign new_load = (rd_load == lag_pkg::LOAD_MAX) ? rd_load
		: rd_load + lag_pkg::LOAD_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lag_pkg::MAX_LINKS; i++) begin
				loads_q[i] <= '0;
			end
		end else if (inc_en) begin
			loads_q[addr] <= new_load;
		end
	end

endmodule

FILE: src/lag_load_aware_hash_select_core.sv
`timescale 1ns / 1ps
// Top level of the load-aware link aggregation selector: sequencer, registers, output stage.
// Depends on lag_pkg, lag_mod_unit, lag_load_table and the assertion macro header.
//
// Each request on the s_ channel is one packet header. The block XORs its fields into a
// 48-bit hash, reduces it modulo the configured link count, and, when the hashed link's
// load is above load_limit, falls back to the lowest link whose load is below it, if any.
// The chosen link's load is incremented with saturation and a result request carrying the
// link index and its new load is offered on the m_ channel.
// From acceptance, a header goes through the modulo reduction, the load check, the fallback
// scan when it is needed, and the load update; the modulo unit works four hash bits a
// cycle and the scan reads one load counter per cycle. One header is in flight at a time.
// A new header is accepted only after the previous one's load update, so any scan and
// any wait for the output register delay it.
// A finished result sits in the output register, so the next header is accepted while it
// waits; if the receiver stalls, the following header stops before its load update until
// the output register is free.
// Configuration writes on cfg_ are always accepted and must arrive only while idle.
// Reset sets link_count to 3, load_limit to 5 and clears all load counters.
`include "lag_load_aware_hash_select_core_assert.svh"

module lag_load_aware_hash_select_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// src_ip, dst_ip, src_mac, dst_mac, src_port, dst_port, outer_vlan, inner_vlan
	input  logic [lag_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// link_index, link_load, zero fill
	output logic [lag_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lag_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lag_pkg::lag_state_t                state_q;
	lag_pkg::lag_state_t                state_next;
	logic [lag_pkg::LINK_COUNT_W-1:0]   count_q;
	logic [lag_pkg::LINK_LOAD_W-1:0]    limit_q;
	logic [lag_pkg::CNT_W-1:0]          n_eff;
	logic [lag_pkg::IDX_W-1:0]          sel_q;
	logic [lag_pkg::IDX_W-1:0]          scan_q;
	logic                               m_valid_q;
	logic [lag_pkg::OUT_DATA_W-1:0]     m_data_q;
	logic [lag_pkg::HASH_W-1:0]         hash;
	lag_pkg::lag_mod_stat_t             mod_stat;
	logic                               mod_start;
	logic [lag_pkg::IDX_W-1:0]          rd_addr;
	logic                               inc_en;
	logic [lag_pkg::LOAD_BITS-1:0]      rd_load;
	logic [lag_pkg::LOAD_BITS-1:0]      new_load;
	logic                               out_free;
	logic                               scan_last;
	logic                               accept;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	always_comb begin
		if (count_q == '0) begin
			n_eff = lag_pkg::CNT_W'(1);
		end else if (lag_pkg::CNT_W'(count_q) > lag_pkg::CNT_W'(lag_pkg::MAX_LINKS)) begin
			n_eff = lag_pkg::CNT_W'(lag_pkg::MAX_LINKS);
		end else begin
			n_eff = lag_pkg::CNT_W'(count_q);
		end
	end

	assign hash = {16'd0, s_tdata[31:0]} ^ {16'd0, s_tdata[63:32]}
		^ s_tdata[111:64] ^ s_tdata[159:112]
		^ {32'd0, s_tdata[175:160]} ^ {32'd0, s_tdata[191:176]}
		^ {36'd0, s_tdata[203:192]} ^ {36'd0, s_tdata[215:204]};

	assign scan_last = (lag_pkg::CNT_W'(scan_q) + lag_pkg::CNT_W'(1)) == n_eff;

	lag_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (hash),
		.divisor  (n_eff),
		.stat     (mod_stat)
	);

	lag_load_table u_loads (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (rd_addr),
		.inc_en   (inc_en),
		.rd_load  (rd_load),
		.new_load (new_load)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lag_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_next = lag_pkg::ST_MOD;
				end
			end
			lag_pkg::ST_MOD: begin
				if (mod_stat.done) begin
					state_next = lag_pkg::ST_CHECK;
				end
			end
			lag_pkg::ST_CHECK: begin
				if (rd_load > lag_pkg::LOAD_BITS'(limit_q)) begin
					state_next = lag_pkg::ST_SCAN;
				end else begin
					state_next = lag_pkg::ST_UPDATE;
				end
			end
			lag_pkg::ST_SCAN: begin
				if (rd_load < lag_pkg::LOAD_BITS'(limit_q) || scan_last) begin
					state_next = lag_pkg::ST_UPDATE;
				end
			end
			lag_pkg::ST_UPDATE: begin
				if (out_free) begin
					state_next = lag_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lag_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mod_start = 1'b0;
		inc_en    = 1'b0;
		rd_addr   = sel_q;
		unique case (state_q)
			lag_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				mod_start = s_tvalid;
			end
			lag_pkg::ST_SCAN: begin
				rd_addr = scan_q;
			end
			lag_pkg::ST_UPDATE: begin
				inc_en = out_free;
			end
			default: begin
				rd_addr = sel_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lag_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
			count_q   <= lag_pkg::LINK_COUNT_RESET;
			limit_q   <= lag_pkg::LOAD_LIMIT_RESET;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lag_pkg::REG_LINK_COUNT) begin
					count_q <= cfg_data[lag_pkg::LINK_COUNT_W-1:0];
				end else if (cfg_index == lag_pkg::REG_LOAD_LIMIT) begin
					limit_q <= cfg_data[lag_pkg::LINK_LOAD_W-1:0];
				end
			end
			if (inc_en) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lag_pkg::ST_MOD && mod_stat.done) begin
			sel_q  <= mod_stat.rem[lag_pkg::IDX_W-1:0];
			scan_q <= '0;
		end else if (state_q == lag_pkg::ST_SCAN) begin
			if (rd_load < lag_pkg::LOAD_BITS'(limit_q)) begin
				sel_q <= scan_q;
			end
			scan_q <= scan_q + lag_pkg::IDX_W'(1);
		end
		if (inc_en) begin
			m_data_q <= {{(lag_pkg::OUT_DATA_W - lag_pkg::LINK_INDEX_W - lag_pkg::LINK_LOAD_W){1'b0}},
				new_load[lag_pkg::LINK_LOAD_W-1:0],
				lag_pkg::LINK_INDEX_W'(sel_q)};
		end
	end

	`LAG_ASSERT_NEXT(a_accept_starts_mod, accept, state_q == lag_pkg::ST_MOD,
		"accepted header did not start the modulo unit")
	`LAG_ASSERT_NEXT(a_update_gives_result, inc_en, m_valid_q && state_q == lag_pkg::ST_IDLE,
		"load update did not produce a result")
	`LAG_ASSERT_SAME(a_index_in_range, m_valid_q,
		lag_pkg::CNT_W'(m_data_q[lag_pkg::LINK_INDEX_W-1:0]) < n_eff,
		"result link index is outside the links in use")

endmodule

FILE: bench/lag_load_aware_hash_select_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lag_load_aware_hash_select_core: stream driver, result monitor and
// an in-bench link choice predictor with its own load counters. Depends on lag_pkg and the RTL.
module lag_load_aware_hash_select_core_tb;

	localparam int unsigned CYCLE_LIMIT = 6_000_000;

	typedef struct packed {
		logic [11:0] inner_vlan;
		logic [11:0] outer_vlan;
		logic [15:0] dst_port;
		logic [15:0] src_port;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [31:0] dst_ip;
		logic [31:0] src_ip;
	} pkt_hdr_t;

	typedef struct packed {
		logic [4:0]                       fill;
		logic [lag_pkg::LINK_LOAD_W-1:0]  link_load;
		logic [lag_pkg::LINK_INDEX_W-1:0] link_index;
	} link_pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [lag_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [lag_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lag_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [lag_pkg::LINK_COUNT_W-1:0] links_in_use = lag_pkg::LINK_COUNT_RESET;
	logic [lag_pkg::LOAD_BITS-1:0] overload_limit = lag_pkg::LOAD_LIMIT_RESET;
	logic [lag_pkg::LOAD_BITS-1:0] link_fill [lag_pkg::MAX_LINKS];

	pkt_hdr_t hdr_backlog [$];
	link_pick_t expected_picks [$];
	link_pick_t got_pick, want_pick;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int unsigned bad_count = 0;
	int unsigned cycle_count = 0;

	lag_load_aware_hash_select_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int eff_links(input logic [lag_pkg::LINK_COUNT_W-1:0] count);
		int n;
		n = int'(count);
		if (n == 0)
			n = 1;
		if (n > lag_pkg::MAX_LINKS)
			n = lag_pkg::MAX_LINKS;
		return n;
	endfunction

	function automatic link_pick_t pick_link(input pkt_hdr_t h);
		logic [47:0] hash;
		int n;
		int sel;
		int i;
		bit found;
		link_pick_t pick;
		hash = {16'b0, h.src_ip} ^ {16'b0, h.dst_ip} ^ h.src_mac ^ h.dst_mac
			^ {32'b0, h.src_port} ^ {32'b0, h.dst_port}
			^ {36'b0, h.outer_vlan} ^ {36'b0, h.inner_vlan};
		n = eff_links(links_in_use);
		sel = int'(hash % 48'(n));
		if (link_fill[sel] > overload_limit) begin
			found = 1'b0;
			for (i = 0; i < n; i++) begin
				if (!found && link_fill[i] < overload_limit) begin
					sel = i;
					found = 1'b1;
				end
			end
		end
		if (link_fill[sel] != lag_pkg::LOAD_MAX)
			link_fill[sel] = link_fill[sel] + lag_pkg::LOAD_BITS'(1);
		pick.fill = '0;
		pick.link_index = sel[lag_pkg::LINK_INDEX_W-1:0];
		pick.link_load = link_fill[sel][lag_pkg::LINK_LOAD_W-1:0];
		return pick;
	endfunction

	function automatic pkt_hdr_t rand_hdr();
		pkt_hdr_t h;
		h.src_ip = $urandom;
		h.dst_ip = $urandom;
		h.src_mac = {16'($urandom), 32'($urandom)};
		h.dst_mac = {16'($urandom), 32'($urandom)};
		h.src_port = 16'($urandom);
		h.dst_port = 16'($urandom);
		h.outer_vlan = 12'($urandom);
		h.inner_vlan = 12'($urandom);
		return h;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		bad_count++;
	endtask

	task automatic write_reg(input logic [lag_pkg::CFG_IDX_W-1:0] idx,
		input logic [lag_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == lag_pkg::REG_LINK_COUNT)
			links_in_use = val[lag_pkg::LINK_COUNT_W-1:0];
		else if (idx == lag_pkg::REG_LOAD_LIMIT)
			overload_limit = val[lag_pkg::LOAD_BITS-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic offer(input pkt_hdr_t h);
		@(negedge clk);
		hdr_backlog.push_back(h);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (hdr_backlog.size() != 0 || s_tvalid || expected_picks.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_picks.push_back(pick_link(pkt_hdr_t'(s_tdata)));
			if (!s_tvalid || s_tready) begin
				if (hdr_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tdata <= hdr_backlog.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_pick = link_pick_t'(m_tdata);
				if (expected_picks.size() == 0) begin
					flag_mismatch($sformatf("unexpected result link %0d load %0d",
						got_pick.link_index, got_pick.link_load));
				end else begin
					want_pick = expected_picks.pop_front();
					if (got_pick.link_index !== want_pick.link_index)
						flag_mismatch($sformatf("link_index got %0d want %0d",
							got_pick.link_index, want_pick.link_index));
					if (got_pick.link_load !== want_pick.link_load)
						flag_mismatch($sformatf("link_load got %0d want %0d",
							got_pick.link_load, want_pick.link_load));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		pkt_hdr_t h;
		int i;
		int p;
		int n;
		int lo;
		int hi;
		int lc;
		int lim;

		for (i = 0; i < lag_pkg::MAX_LINKS; i++)
			link_fill[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: all-zero and all-one headers, then each field at its maximum.
		offer('0);
		offer('1);
		for (i = 0; i < 8; i++) begin
			h = '0;
			case (i)
				0: h.src_ip = '1;
				1: h.dst_ip = '1;
				2: h.src_mac = '1;
				3: h.dst_mac = '1;
				4: h.src_port = '1;
				5: h.dst_port = '1;
				6: h.outer_vlan = '1;
				default: h.inner_vlan = '1;
			endcase
			offer(h);
		end
		wait_drained();

		// With a zero limit every loaded link is overloaded and none can take over.
		write_reg(lag_pkg::REG_LINK_COUNT, lag_pkg::CFG_DATA_W'(8));
		write_reg(lag_pkg::REG_LOAD_LIMIT, lag_pkg::CFG_DATA_W'(0));
		h = '0;
		h.src_ip = 32'd7;
		offer(h);
		offer(h);
		wait_drained();

		write_reg(lag_pkg::REG_LINK_COUNT, lag_pkg::CFG_DATA_W'(0));
		offer(rand_hdr());
		offer(rand_hdr());
		wait_drained();

		write_reg(lag_pkg::REG_LINK_COUNT, lag_pkg::CFG_DATA_W'(15));
		offer(rand_hdr());
		offer(rand_hdr());
		wait_drained();

		// Link 1 sits exactly at the limit, then goes over it.
		write_reg(lag_pkg::REG_LINK_COUNT, lag_pkg::CFG_DATA_W'(3));
		write_reg(lag_pkg::REG_LOAD_LIMIT, lag_pkg::CFG_DATA_W'(link_fill[1]));
		h = '0;
		h.src_ip = 32'd1;
		for (i = 0; i < 4; i++)
			offer(h);
		wait_drained();

		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 86; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 86; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			case (p)
				0: lc = 8;
				1: lc = 1;
				5: lc = 0;
				6: lc = int'($urandom_range(9, 15));
				default: lc = int'($urandom_range(1, 8));
			endcase
			n = eff_links(lag_pkg::LINK_COUNT_W'(lc));
			lo = int'(lag_pkg::LOAD_MAX);
			hi = 0;
			for (i = 0; i < n; i++) begin
				if (int'(link_fill[i]) < lo)
					lo = int'(link_fill[i]);
				if (int'(link_fill[i]) > hi)
					hi = int'(link_fill[i]);
			end
			case (p)
				2: lim = int'(lag_pkg::LOAD_MAX);
				3: lim = 0;
				default: begin
					case ($urandom_range(0, 2))
						0: lim = lo + int'($urandom_range(0, 3));
						1: lim = hi;
						default: lim = int'($urandom_range(lo, hi + 8));
					endcase
				end
			endcase
			write_reg(lag_pkg::REG_LINK_COUNT, lag_pkg::CFG_DATA_W'(lc));
			write_reg(lag_pkg::REG_LOAD_LIMIT, lag_pkg::CFG_DATA_W'(lim));
			repeat (144)
				offer(rand_hdr());
			wait_drained();
		end

		repeat (40) @(posedge clk);
		@(negedge clk);
		if (bad_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/lag_pkg.sv
src/lag_mod_unit.sv
src/lag_load_table.sv
src/lag_load_aware_hash_select_core.sv
bench/lag_load_aware_hash_select_core_tb.sv
